@@ rtl/core/sem_pkg.sv @@
// ----------------------------------------------------------------------------
// sem_pkg
// shared types and constants of the sobel edge magnitude block
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int PIX_W          = 8;
    localparam int POS_W          = 10;
    localparam int CFG_DATA_W     = 11;
    localparam int CFG_INDEX_W    = 2;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;
    localparam int MIN_SIZE       = 3;
    localparam int MAG_MAX        = 255;
    localparam int FIFO_AW        = 3;
    localparam int FIFO_DEPTH     = 1 << FIFO_AW;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;

    // row-major 3x3 neighborhood, entry 0 is top left
    typedef pix_t [8:0] window_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             done;
    } pos_t;

endpackage

@@ rtl/core/sem_gradient.sv @@
// ----------------------------------------------------------------------------
// sem_gradient
// sobel gradients of one window, |gx|+|gy| saturated, registered result
// ----------------------------------------------------------------------------
module sem_gradient (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             win_valid,
    input  sem_pkg::window_t window,
    input  sem_pkg::pos_t    win_pos,
    output logic             res_valid,
    output sem_pkg::pix_t    res_mag,
    output sem_pkg::pos_t    res_pos
);
    import sem_pkg::*;

    logic signed [11:0] k [9];
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic        [11:0] ax;
    logic        [11:0] ay;
    logic        [11:0] sum;
    pix_t               mag;
    logic               res_valid_reg;
    pix_t               res_mag_reg;
    pos_t               res_pos_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            k[i] = signed'({4'b0000, window[i]});
        end
        gx  = (k[2] - k[0]) + ((k[5] - k[3]) <<< 1) + (k[8] - k[6]);
        gy  = (k[6] - k[0]) + ((k[7] - k[1]) <<< 1) + (k[8] - k[2]);
        ax  = gx[11] ? 12'(-gx) : 12'(gx);
        ay  = gy[11] ? 12'(-gy) : 12'(gy);
        sum = ax + ay;
        mag = (sum > 12'(MAG_MAX)) ? PIX_W'(MAG_MAX) : sum[PIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= win_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_valid)
        begin
            res_mag_reg <= mag;
            res_pos_reg <= win_pos;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_mag   = res_mag_reg;
    assign res_pos   = res_pos_reg;

endmodule

@@ rtl/core/sobel_edge_magnitude_top.sv @@
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_top
// 3x3 sobel edge magnitude over a raster pixel stream
// ----------------------------------------------------------------------------
// pixels enter in raster order on in_valid/in_stall/pixel, one item per
// clock when nothing downstream stalls. one result item leaves on
// out_valid/out_stall for each interior centre, carrying |gx|+|gy|
// saturated to 255, the centre's row and column, and frame_done on the
// last interior result of a frame. border centres give no item.
// the result for centre (r,c) is caused by pixel (r+1,c+1); it passes the
// line buffer read with the accept, window shift, gradient register and
// output queue. throughput is one pixel per cycle while in_stall is low,
// set by the single line buffer memory (one read and one write port, one
// entry per column). a stall on the output fills an 8-item queue; in_stall
// rises when the queue plus the items in flight could reach its depth, so
// nothing is lost. frame_width/frame_height must be written through
// cfg_write/cfg_index/cfg_data while the block is idle, which the block
// does not enforce; sizes below 3 act as 3, above the maximum as it. reset
// clears the counters, window, queue and sizes (640x480); the line buffer
// has no clearing pass, the first two rows of a frame fill it.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_top #(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [sem_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [sem_pkg::PIX_W-1:0]          pixel,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [sem_pkg::PIX_W-1:0]          edge_magnitude,
    output logic [sem_pkg::POS_W-1:0]          out_row,
    output logic [sem_pkg::POS_W-1:0]          out_col,
    output logic                               frame_done
);
    import sem_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int HAW = $clog2(MAX_HEIGHT);
    localparam int SW  = $clog2(MAX_WIDTH + 1);
    localparam int HSW = $clog2(MAX_HEIGHT + 1);
    localparam int CW  = (SW > CFG_DATA_W) ? SW : CFG_DATA_W;
    localparam int HCW = (HSW > CFG_DATA_W) ? HSW : CFG_DATA_W;

    // configuration
    logic [CFG_DATA_W-1:0] frame_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;
    logic [CW-1:0]         fw_ext;
    logic [HCW-1:0]        fh_ext;
    logic [SW-1:0]         width_eff;
    logic [HSW-1:0]        height_eff;

    // position counters
    logic [AW-1:0]  col_reg;
    logic [AW-1:0]  col_next;
    logic [HAW-1:0] row_reg;
    logic [HAW-1:0] row_next;
    logic           col_wrap;
    logic [AW-1:0]  c_eff;
    logic [HSW-1:0] row_inc;
    logic [HAW-1:0] r_eff;
    logic [SW-1:0]  c_inc;
    logic [HSW-1:0] r_inc;
    logic           emit;
    pos_t           pos;
    logic [HAW-1:0] r_m1;
    logic [AW-1:0]  c_m1;
    logic           in_accept;

    // line buffer: upper row in the high byte, middle row in the low byte
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;
    pix_t               rd_up;
    pix_t               rd_mid;

    // stage after the accept
    logic          s1_valid_reg;
    logic          s1_emit_reg;
    pix_t          s1_pix_reg;
    logic [AW-1:0] s1_addr_reg;
    pos_t          s1_pos_reg;

    // window stage
    window_t window_reg;
    window_t window_next;
    logic    win_valid_reg;
    pos_t    win_pos_reg;

    // gradient stage
    logic res_valid;
    pix_t res_mag;
    pos_t res_pos;

    // output queue
    pix_t                fifo_mag_reg [FIFO_DEPTH];
    pos_t                fifo_pos_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg;
    logic [FIFO_AW-1:0]  rd_ptr_reg;
    logic [FIFO_AW:0]    count_reg;
    logic [FIFO_AW:0]    count_next;
    logic [FIFO_AW+1:0]  pending;
    logic                pop;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_DATA_W'(RESET_WIDTH);
            frame_height_reg <= CFG_DATA_W'(RESET_HEIGHT);
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // size clamp, counter wrap and centre position
    always_comb
    begin
        fw_ext = CW'(frame_width_reg);
        fh_ext = HCW'(frame_height_reg);
        if (fw_ext < CW'(MIN_SIZE))
            width_eff = SW'(MIN_SIZE);
        else if (fw_ext > CW'(MAX_WIDTH))
            width_eff = SW'(MAX_WIDTH);
        else
            width_eff = SW'(fw_ext);
        if (fh_ext < HCW'(MIN_SIZE))
            height_eff = HSW'(MIN_SIZE);
        else if (fh_ext > HCW'(MAX_HEIGHT))
            height_eff = HSW'(MAX_HEIGHT);
        else
            height_eff = HSW'(fh_ext);

        col_wrap = SW'(col_reg) >= width_eff;
        c_eff    = col_wrap ? '0 : col_reg;
        row_inc  = col_wrap ? HSW'(row_reg) + HSW'(1) : HSW'(row_reg);
        r_eff    = (row_inc >= height_eff) ? '0 : row_inc[HAW-1:0];

        c_inc = SW'(c_eff) + SW'(1);
        r_inc = HSW'(r_eff) + HSW'(1);
        if (c_inc >= width_eff)
        begin
            col_next = '0;
            row_next = (r_inc >= height_eff) ? '0 : r_inc[HAW-1:0];
        end
        else
        begin
            col_next = c_inc[AW-1:0];
            row_next = r_eff;
        end

        emit     = (r_eff >= HAW'(2)) && (c_eff >= AW'(2));
        r_m1     = r_eff - HAW'(1);
        c_m1     = c_eff - AW'(1);
        pos.row  = POS_W'(r_m1);
        pos.col  = POS_W'(c_m1);
        pos.done = (HSW'(r_eff) == height_eff - HSW'(1))
                && (SW'(c_eff) == width_eff - SW'(1));
    end

    assign pending   = (FIFO_AW+2)'(count_reg)
                     + (FIFO_AW+2)'(s1_valid_reg && s1_emit_reg)
                     + (FIFO_AW+2)'(win_valid_reg)
                     + (FIFO_AW+2)'(res_valid);
    assign in_stall  = pending >= (FIFO_AW+2)'(FIFO_DEPTH);
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            s1_emit_reg  <= in_accept && emit;
            if (in_accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pix_reg  <= pixel;
            s1_addr_reg <= c_eff;
            s1_pos_reg  <= pos;
        end
    end

    // line buffer read at accept, rotated write in the following cycle
    assign rd_up  = rd_data_reg[2*PIX_W-1:PIX_W];
    assign rd_mid = rd_data_reg[PIX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            line_mem[s1_addr_reg] <= {rd_mid, s1_pix_reg};
        end
        if (in_accept)
        begin
            rd_data_reg <= line_mem[c_eff];
        end
    end

    // window shift
    always_comb
    begin
        window_next    = window_reg;
        window_next[0] = window_reg[1];
        window_next[1] = window_reg[2];
        window_next[2] = rd_up;
        window_next[3] = window_reg[4];
        window_next[4] = window_reg[5];
        window_next[5] = rd_mid;
        window_next[6] = window_reg[7];
        window_next[7] = window_reg[8];
        window_next[8] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            win_valid_reg <= 1'b0;
        end
        else
        begin
            win_valid_reg <= s1_valid_reg && s1_emit_reg;
            if (s1_valid_reg)
            begin
                window_reg <= window_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            win_pos_reg <= s1_pos_reg;
        end
    end

    sem_gradient u_gradient (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (win_valid_reg),
        .window    (window_reg),
        .win_pos   (win_pos_reg),
        .res_valid (res_valid),
        .res_mag   (res_mag),
        .res_pos   (res_pos)
    );

    // output queue
    assign out_valid      = count_reg != '0;
    assign pop            = out_valid && !out_stall;
    assign edge_magnitude = fifo_mag_reg[rd_ptr_reg];
    assign out_row        = fifo_pos_reg[rd_ptr_reg].row;
    assign out_col        = fifo_pos_reg[rd_ptr_reg].col;
    assign frame_done     = fifo_pos_reg[rd_ptr_reg].done;

    always_comb
    begin
        count_next = count_reg;
        if (res_valid && !pop)
            count_next = count_reg + (FIFO_AW+1)'(1);
        else if (!res_valid && pop)
            count_next = count_reg - (FIFO_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (res_valid)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            fifo_mag_reg[wr_ptr_reg] <= res_mag;
            fifo_pos_reg[wr_ptr_reg] <= res_pos;
        end
    end

    // checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("output queue beyond its depth");

    a_window_source: assert property (@(posedge clk) disable iff (!rst_n)
        win_valid_reg |-> $past(s1_valid_reg && s1_emit_reg))
        else $error("window result without an interior item");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s1_valid_reg) |-> (c_eff != s1_addr_reg))
        else $error("line buffer read and write hit the same column");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !pop) |-> (count_reg < (FIFO_AW+1)'(FIFO_DEPTH)))
        else $error("item pushed into a full output queue");

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sobel edge magnitude block: a predictor of
// the line stores, window and counters runs on every accepted pixel item
// and queues the expected edge items, which are compared field by field as
// they leave. directed frames come first, then the size limits, resizing
// in the middle of a frame, a long output hold-off and random frames, with
// random gaps on both channels
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sem_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 780;
    localparam int MAX_REPORTS    = 50;
    localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_HI = 2'd3;

    typedef struct packed {
        pix_t mag;
        pos_t pos;
    } edge_item_t;

    typedef enum {TEX_FULL, TEX_SOFT, TEX_BINARY} texture_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    pix_t                   pixel = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    pix_t                   edge_magnitude;
    logic [POS_W-1:0]       out_row;
    logic [POS_W-1:0]       out_col;
    logic                   frame_done;

    // predictor state
    pix_t                   upper_line [0:DEF_MAX_WIDTH-1];
    pix_t                   middle_line [0:DEF_MAX_WIDTH-1];
    window_t                nbhd;
    int unsigned            col_pos;
    int unsigned            row_pos;
    logic [CFG_DATA_W-1:0]  frame_w;
    logic [CFG_DATA_W-1:0]  frame_h;
    edge_item_t             edges_due [$];

    int       err_count = 0;
    int       items_sent = 0;
    int       quiet_cycles = 0;
    int       hold_req = 0;
    bit       send_idle_en = 1'b1;
    bit       recv_idle_en = 1'b1;
    texture_t texture = TEX_FULL;
    int       soft_base = 0;

    sobel_edge_magnitude_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pixel          (pixel),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .edge_magnitude (edge_magnitude),
        .out_row        (out_row),
        .out_col        (out_col),
        .frame_done     (frame_done)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                              input int unsigned hi);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > hi)
            return hi;
        return 32'(v);
    endfunction

    // position of the next pixel once any pending row or frame wrap is applied
    function automatic void next_position(output int unsigned c, output int unsigned r);
        c = col_pos;
        r = row_pos;
        if (c >= clamp_dim(frame_w, DEF_MAX_WIDTH))
        begin
            c = 0;
            r++;
        end
        if (r >= clamp_dim(frame_h, DEF_MAX_HEIGHT))
            r = 0;
    endfunction

    function automatic bit at_frame_start();
        int unsigned c;
        int unsigned r;
        next_position(c, r);
        return (c == 0 && r == 0);
    endfunction

    function automatic void reset_predictor();
        for (int i = 0; i < DEF_MAX_WIDTH; i++)
        begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        nbhd = '0;
        col_pos = 0;
        row_pos = 0;
        frame_w = CFG_DATA_W'(RESET_WIDTH);
        frame_h = CFG_DATA_W'(RESET_HEIGHT);
    endfunction

    function automatic void sobel_predict(input pix_t pix);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        pix_t        up;
        pix_t        mid;
        int          gx;
        int          gy;
        int          mag;
        edge_item_t  e;
        w = clamp_dim(frame_w, DEF_MAX_WIDTH);
        h = clamp_dim(frame_h, DEF_MAX_HEIGHT);
        next_position(c, r);
        up = upper_line[c];
        mid = middle_line[c];
        upper_line[c] = mid;
        middle_line[c] = pix;
        nbhd[0] = nbhd[1];
        nbhd[1] = nbhd[2];
        nbhd[2] = up;
        nbhd[3] = nbhd[4];
        nbhd[4] = nbhd[5];
        nbhd[5] = mid;
        nbhd[6] = nbhd[7];
        nbhd[7] = nbhd[8];
        nbhd[8] = pix;
        if (r >= 2 && c >= 2)
        begin
            gx = (int'(nbhd[2]) - int'(nbhd[0])) + 2 * (int'(nbhd[5]) - int'(nbhd[3]))
               + (int'(nbhd[8]) - int'(nbhd[6]));
            gy = (int'(nbhd[6]) - int'(nbhd[0])) + 2 * (int'(nbhd[7]) - int'(nbhd[1]))
               + (int'(nbhd[8]) - int'(nbhd[2]));
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            if (mag > MAG_MAX)
                mag = MAG_MAX;
            e.mag = pix_t'(mag);
            e.pos.row = POS_W'(r - 1);
            e.pos.col = POS_W'(c - 1);
            e.pos.done = (r == h - 1 && c == w - 1);
            edges_due.push_back(e);
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    always @(posedge clk)
    begin : edge_check
        edge_item_t want;
        if (!rst_n)
        begin
            reset_predictor();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_w = cfg_data;
                    REG_FRAME_HEIGHT: frame_h = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                sobel_predict(pixel);
            if (out_valid && !out_stall)
            begin
                if (edges_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected item row %0d col %0d",
                                              out_row, out_col));
                end
                else
                begin
                    want = edges_due.pop_front();
                    if (edge_magnitude !== want.mag)
                        report_mismatch($sformatf("edge_magnitude %0d, want %0d at %0d,%0d",
                                                  edge_magnitude, want.mag,
                                                  want.pos.row, want.pos.col));
                    if (out_row !== want.pos.row)
                        report_mismatch($sformatf("out_row %0d, want %0d",
                                                  out_row, want.pos.row));
                    if (out_col !== want.pos.col)
                        report_mismatch($sformatf("out_col %0d, want %0d",
                                                  out_col, want.pos.col));
                    if (frame_done !== want.pos.done)
                        report_mismatch($sformatf("frame_done %0b, want %0b at %0d,%0d",
                                                  frame_done, want.pos.done,
                                                  want.pos.row, want.pos.col));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin : receiver
        int left;
        bit level;
        int p;
        left = 0;
        level = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                left = hold_req;
                level = 1'b1;
                hold_req = 0;
            end
            else if (left <= 0)
            begin
                p = $urandom_range(0, 99);
                if (!recv_idle_en)
                begin
                    level = 1'b0;
                    left = 1;
                end
                else if (p < 55)
                begin
                    level = 1'b0;
                    left = $urandom_range(1, 10);
                end
                else if (p < 88)
                begin
                    level = 1'b1;
                    left = $urandom_range(1, 3);
                end
                else if (p < 96)
                begin
                    level = 1'b1;
                    left = $urandom_range(6, 30);
                end
                else
                begin
                    level = 1'b0;
                    left = $urandom_range(40, 120);
                end
            end
            out_stall <= level;
            left--;
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (!send_idle_en || p < 55)
            return 0;
        if (p < 88)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void shuffle_texture();
        texture = texture_t'($urandom_range(0, 2));
        soft_base = $urandom_range(0, 224);
    endfunction

    function automatic pix_t rand_pixel();
        int p;
        p = $urandom_range(0, 9);
        case (texture)
            TEX_SOFT:   return pix_t'(soft_base + $urandom_range(0, 31));
            TEX_BINARY: return (p < 5) ? 8'hFF : 8'h00;
            default:
            begin
                if (p == 0)
                    return 8'h00;
                if (p == 1)
                    return 8'hFF;
                return pix_t'($urandom_range(0, 255));
            end
        endcase
    endfunction

    task automatic send_pixel(input pix_t v);
        int   gap;
        logic stalled;
        in_valid <= 1'b1;
        pixel <= v;
        do
        begin
            @(posedge clk);
            stalled = in_stall;
            @(negedge clk);
        end
        while (stalled);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic complete_frame();
        do
            send_pixel(rand_pixel());
        while (!at_frame_start());
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (edges_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // sizes below the minimum, spare indexes, a saturating vertical edge
    task automatic test_register_map();
        set_size(11'd0, 11'd1);
        write_reg(IDX_SPARE_LO, 11'h7FF);
        write_reg(IDX_SPARE_HI, 11'($urandom));
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_pixel((c == 2) ? 8'hFF : 8'h00);
        wait_idle();
    endtask

    task automatic test_pixel_extremes();
        set_size(11'd4, 11'd4);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                send_pixel(((r + 2 * c) % 3 == 0) ? 8'hFF : 8'h00);
        wait_idle();
    endtask

    // the wide frame also fills the line store entries that later resizing reaches
    task automatic test_size_extremes();
        shuffle_texture();
        set_size(11'd1025, 11'd3);
        repeat (72) send_pixel(rand_pixel());
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 11'd72);
        complete_frame();
        wait_idle();
        shuffle_texture();
        set_size(11'd3, 11'd2047);
        repeat (42) send_pixel(rand_pixel());
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 11'd15);
        complete_frame();
        wait_idle();
        set_size(11'd1024, 11'd1024);
    endtask

    task automatic test_mid_frame_resize();
        shuffle_texture();
        set_size(11'd8, 11'd6);
        repeat (21) send_pixel(rand_pixel());
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 11'd4);
        repeat (9) send_pixel(rand_pixel());
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 11'd10);
        repeat (13) send_pixel(rand_pixel());
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 11'd9);
        repeat (40) send_pixel(rand_pixel());
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 11'd2);
        complete_frame();
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 11'd7);
        repeat (15) send_pixel(rand_pixel());
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 11'd12);
        complete_frame();
        wait_idle();
    endtask

    task automatic test_back_pressure();
        shuffle_texture();
        set_size(11'd6, 11'd5);
        send_idle_en = 1'b0;
        hold_req = 400;
        repeat (3) complete_frame();
        send_idle_en = 1'b1;
        wait_idle();
        repeat (2) complete_frame();
        wait_idle();
    endtask

    task automatic test_random_frames();
        int first;
        int p;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            p = $urandom_range(0, 99);
            if (p < 80)
            begin
                w = 11'($urandom_range(3, 12));
                h = 11'($urandom_range(3, 8));
            end
            else if (p < 92)
            begin
                w = 11'($urandom_range(13, 70));
                h = 11'($urandom_range(3, 5));
            end
            else
            begin
                w = 11'($urandom_range(0, 2));
                h = 11'($urandom_range(0, 9));
            end
            p = $urandom_range(0, 9);
            send_idle_en = (p != 0 && p != 1);
            recv_idle_en = (p != 0 && p != 2);
            shuffle_texture();
            set_size(w, h);
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 40)) send_pixel(rand_pixel());
                wait_idle();
                if ($urandom_range(0, 1))
                    write_reg(REG_FRAME_WIDTH, 11'($urandom_range(0, 16)));
                else
                    write_reg(REG_FRAME_HEIGHT, 11'($urandom_range(0, 10)));
            end
            complete_frame();
            wait_idle();
        end
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_register_map();
        test_pixel_extremes();
        test_size_extremes();
        test_mid_frame_resize();
        test_back_pressure();
        test_random_frames();
        wait_idle();
        if (edges_due.size() != 0)
            report_mismatch($sformatf("%0d expected items never arrived", edges_due.size()));
        if (err_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
